// ===== rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared types and codes for the rational arithmetic unit
// Command, status codes, payload words and controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;

  localparam int unsigned CmdBits    = 3;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned FieldBits  = 32;

  typedef enum logic [CmdBits-1:0] {
    CMD_ADD_F = 3'd0,
    CMD_SUB_F = 3'd1,
    CMD_MUL_F = 3'd2,
    CMD_DIV_F = 3'd3,
    CMD_ADD_I = 3'd4,
    CMD_SUB_I = 3'd5,
    CMD_MUL_I = 3'd6,
    CMD_DIV_I = 3'd7
  } cmd_t;

  typedef enum logic [StatusBits-1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic [CmdBits-1:0]          command;
    logic signed [FieldBits-1:0] left_numerator;
    logic signed [FieldBits-1:0] left_denominator;
    logic signed [FieldBits-1:0] right_numerator;
    logic signed [FieldBits-1:0] right_denominator;
  } in_word_t;

  typedef struct packed {
    logic signed [FieldBits-1:0] result_numerator;
    logic signed [FieldBits-1:0] result_denominator;
    logic [StatusBits-1:0]       status;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture operands
    logic mul;      // run one product step
    logic sum;      // form raw n, d and magnitudes
    logic gcd;      // one binary-gcd step
    logic div_init; // start exact divisions
    logic div;      // one restoring division bit
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mul_last;
    logic gcd_done;
    logic div_last;
    logic bypass;   // zero denominator or integer divide by zero
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/rau_datapath.sv =====
// ----------------------------------------------------------------------------
// rau_datapath: operand registers, shared multiplier, binary gcd, dividers
// Products run through one multiplier into product registers; gcd is binary (Stein);
// the two exact divisions run bit-serial side by side.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_datapath #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                       clk,
  input  wire rau_pkg::dp_cmd_t           cmd_i,
  output rau_pkg::dp_sts_t                sts_o,
  input  wire logic [rau_pkg::CmdBits-1:0] op_i,
  input  wire logic [WORD_BITS-1:0]       ln_i,
  input  wire logic [WORD_BITS-1:0]       ld_i,
  input  wire logic [WORD_BITS-1:0]       rn_i,
  input  wire logic [WORD_BITS-1:0]       rd_i,
  output logic [WORD_BITS-1:0]            res_n_o,
  output logic [WORD_BITS-1:0]            res_d_o,
  output logic [rau_pkg::StatusBits-1:0]  status_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned SW = $clog2(W + 1);
  localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

  logic [rau_pkg::CmdBits-1:0] op_r;
  logic [W-1:0] ln_r, ld_r, rn_r, rd_r;
  logic [W-1:0] p_r [4];   // ln*rd, rn*ld, ln*rn, ld*rd/ld*rn per command
  logic [1:0]   mi_r;
  logic [W-1:0] n_r, d_r, a_r, b_r;
  logic [SW-1:0] k_r;
  logic [W-1:0] qn_r, qd_r, rmn_r, rmd_r, g_r;
  logic [SW-1:0] bit_r;
  logic         nneg_r, dneg_r;
  logic [rau_pkg::StatusBits-1:0] st_r;

  // multiplier operand select, one product per cycle
  logic [W-1:0] ma, mb, prod;
  always_comb begin
    case (mi_r)
      2'd0:    begin ma = ln_r; mb = rd_r; end
      2'd1:    begin ma = rn_r; mb = ld_r; end
      2'd2:    begin ma = ln_r; mb = rn_r; end
      default: begin
        ma = ld_r;
        mb = (op_r == rau_pkg::CMD_DIV_F || op_r == rau_pkg::CMD_DIV_I) ? rn_r : rd_r;
      end
    endcase
    prod = ma * mb;
  end

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (~v + ONE) : v;
  endfunction

  // raw numerator and denominator from products
  logic [W-1:0] raw_n, raw_d;
  always_comb begin
    case (op_r)
      rau_pkg::CMD_ADD_F: begin raw_n = p_r[0] + p_r[1]; raw_d = p_r[3]; end
      rau_pkg::CMD_SUB_F: begin raw_n = p_r[0] - p_r[1]; raw_d = p_r[3]; end
      rau_pkg::CMD_MUL_F: begin raw_n = p_r[2];          raw_d = p_r[3]; end
      rau_pkg::CMD_DIV_F: begin raw_n = p_r[0];          raw_d = p_r[3]; end
      rau_pkg::CMD_ADD_I: begin raw_n = ln_r + p_r[1];   raw_d = ld_r;   end
      rau_pkg::CMD_SUB_I: begin raw_n = ln_r - p_r[1];   raw_d = ld_r;   end
      rau_pkg::CMD_MUL_I: begin raw_n = p_r[2];          raw_d = ld_r;   end
      default:            begin raw_n = ln_r;            raw_d = p_r[3]; end
    endcase
  end

  // binary gcd step: strip common twos, halve a lone even value, then subtract odd values
  logic [W-1:0] a_nx, b_nx;
  logic [SW-1:0] k_nx;
  logic gdone;
  always_comb begin
    a_nx = a_r; b_nx = b_r; k_nx = k_r;
    gdone = (a_r == '0) || (b_r == '0);
    if (!gdone) begin
      if (!a_r[0] && !b_r[0]) begin
        a_nx = a_r >> 1; b_nx = b_r >> 1; k_nx = k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_nx = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nx = b_r >> 1;
      end else if (a_r >= b_r) begin
        a_nx = a_r - b_r;
      end else begin
        b_nx = b_r - a_r;
      end
    end
  end
  logic [W-1:0] gsum;
  assign gsum = (a_r | b_r) << k_r;

  // restoring division bit for both quotients
  logic [W:0] tn, td;
  assign tn = {rmn_r, qn_r[W-1]};
  assign td = {rmd_r, qd_r[W-1]};

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      op_r <= op_i; ln_r <= ln_i; ld_r <= ld_i; rn_r <= rn_i; rd_r <= rd_i;
      mi_r <= 2'd0;
    end
    if (cmd_i.mul) begin
      p_r[mi_r] <= prod;
      mi_r <= mi_r + 2'd1;
    end
    if (cmd_i.sum) begin
      n_r <= raw_n; d_r <= raw_d;
      a_r <= mag(raw_n); b_r <= mag(raw_d); k_r <= '0;
      if (op_r == rau_pkg::CMD_DIV_I && rn_r == '0) begin
        res_n_o <= ln_r; res_d_o <= ld_r; st_r <= rau_pkg::ST_DIV_ZERO;
      end else if (raw_d == '0) begin
        res_n_o <= raw_n; res_d_o <= ONE; st_r <= rau_pkg::ST_ZERO_DEN;
      end else begin
        st_r <= rau_pkg::ST_OK;
      end
    end
    if (cmd_i.gcd) begin
      a_r <= a_nx; b_r <= b_nx; k_r <= k_nx;
    end
    if (cmd_i.div_init) begin
      g_r <= gsum;
      qn_r <= mag(n_r); qd_r <= mag(d_r);
      rmn_r <= '0; rmd_r <= '0; bit_r <= '0;
      nneg_r <= n_r[W-1]; dneg_r <= d_r[W-1];
    end
    if (cmd_i.div) begin
      if (tn >= {1'b0, g_r}) begin
        rmn_r <= W'(tn - {1'b0, g_r}); qn_r <= {qn_r[W-2:0], 1'b1};
      end else begin
        rmn_r <= tn[W-1:0]; qn_r <= {qn_r[W-2:0], 1'b0};
      end
      if (td >= {1'b0, g_r}) begin
        rmd_r <= W'(td - {1'b0, g_r}); qd_r <= {qd_r[W-2:0], 1'b1};
      end else begin
        rmd_r <= td[W-1:0]; qd_r <= {qd_r[W-2:0], 1'b0};
      end
      bit_r <= bit_r + 1'b1;
      if (bit_r == SW'(W - 1)) begin
        res_n_o <= nneg_r ? ~({qn_r[W-2:0], (tn >= {1'b0, g_r})}) + ONE
                          :  {qn_r[W-2:0], (tn >= {1'b0, g_r})};
        res_d_o <= dneg_r ? ~({qd_r[W-2:0], (td >= {1'b0, g_r})}) + ONE
                          :  {qd_r[W-2:0], (td >= {1'b0, g_r})};
      end
    end
  end

  assign status_o        = st_r;
  assign sts_o.mul_last  = (mi_r == 2'd3);
  assign sts_o.gcd_done  = gdone;
  assign sts_o.div_last  = (bit_r == SW'(W - 1));
  assign sts_o.bypass    = (st_r != rau_pkg::ST_OK);

endmodule
`default_nettype wire

// ===== rtl/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl: sequencer for the rational arithmetic unit
// Steps load, products, raw result, gcd, exact divisions and output strobe.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  output logic                  done,
  output rau_pkg::dp_cmd_t      cmd_o,
  input  wire rau_pkg::dp_sts_t sts_i
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_SUM  = 7'b0000100,
    S_CHK  = 7'b0001000,
    S_GCD  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd_o = '0;
    case (state_r)
      S_IDLE: if (start) begin cmd_o.load = 1'b1; state_nxt = S_MUL; end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        if (sts_i.mul_last) state_nxt = S_SUM;
      end
      S_SUM: begin cmd_o.sum = 1'b1; state_nxt = S_CHK; end
      S_CHK: state_nxt = sts_i.bypass ? S_OUT : S_GCD;
      S_GCD: begin
        if (sts_i.gcd_done) begin cmd_o.div_init = 1'b1; state_nxt = S_DIV; end
        else cmd_o.gcd = 1'b1;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_last) state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_OUT);

endmodule
`default_nettype wire

// ===== rtl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction add/sub/mul/div with gcd reduction
//
//   channel  | ports                 | handshake
//   input    | in_word               | start high, busy low
//   result   | out_word              | out_valid, one cycle, no stall
//
// An item runs through the four products, the raw result, the bypass check,
// the binary-gcd steps (divider setup once gcd is done), the bit-serial
// divisions over the WORD_BITS quotient bits, then the output step. Each gcd
// subtract leaves an even value, so a shift or the end of the loop follows.
// Bypassed results (zero denominator, integer divide by zero) skip to output.
// rst_n is synchronous; busy stays high from acceptance to the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arithmetic_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire rau_pkg::in_word_t in_word,
  output logic                   out_valid,
  output rau_pkg::out_word_t     out_word
);

  localparam int unsigned WORD_BITS = rau_pkg::FieldBits;

  rau_pkg::dp_cmd_t dp_cmd;
  rau_pkg::dp_sts_t dp_sts;
  logic [WORD_BITS-1:0] res_n, res_d;
  logic [rau_pkg::StatusBits-1:0] status;

  rau_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (out_valid),
    .cmd_o (dp_cmd),
    .sts_i (dp_sts)
  );

  rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk      (clk),
    .cmd_i    (dp_cmd),
    .sts_o    (dp_sts),
    .op_i     (in_word.command),
    .ln_i     (WORD_BITS'(in_word.left_numerator)),
    .ld_i     (WORD_BITS'(in_word.left_denominator)),
    .rn_i     (WORD_BITS'(in_word.right_numerator)),
    .rd_i     (WORD_BITS'(in_word.right_denominator)),
    .res_n_o  (res_n),
    .res_d_o  (res_d),
    .status_o (status)
  );

  assign out_word.result_numerator   = res_n;
  assign out_word.result_denominator = res_d;
  assign out_word.status             = status;

  // a result strobe only follows work in progress
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe while idle");
  // after the strobe the unit is free again
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");
  // accepting an item makes the unit busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept without busy");

endmodule
`default_nettype wire
